// ===== design/reply_frame_parser_assert.svh =====
// ----------------------------------------------------------------------------
// reply_frame_parser_assert.svh
// Assertion macros shared by the reply frame parser modules.
// ----------------------------------------------------------------------------
`ifndef REPLY_FRAME_PARSER_ASSERT_SVH
`define REPLY_FRAME_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define RFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rfp same-cycle check failed");
// next-cycle implication, disabled during reset
`define RFP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rfp next-cycle check failed");
`else
`define RFP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RFP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfp_pkg
// Byte codes, result kinds, parser phases and the result record.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h4F;
    localparam logic [7:0] SYNC_SECOND = 8'h4B;
    localparam logic [7:0] FN_ACK      = 8'h4F;
    localparam logic [7:0] FN_CURTAIN  = 8'h4D;
    localparam logic [7:0] FN_INIT     = 8'h49;
    localparam logic [7:0] FN_SENSORS  = 8'h53;
    localparam logic [7:0] FN_LEDS     = 8'h4C;

    localparam logic [2:0] KIND_ACK       = 3'd0;
    localparam logic [2:0] KIND_CURTAIN   = 3'd1;
    localparam logic [2:0] KIND_INIT      = 3'd2;
    localparam logic [2:0] KIND_SENSORS   = 3'd3;
    localparam logic [2:0] KIND_LED       = 3'd4;
    localparam logic [2:0] KIND_LED_EMPTY = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd6;

    typedef enum logic [8:0] {
        PH_HUNT_O  = 9'b000000001,
        PH_HUNT_K  = 9'b000000010,
        PH_FUNC    = 9'b000000100,
        PH_CUR_POS = 9'b000001000,
        PH_CUR_MAX = 9'b000010000,
        PH_INIT    = 9'b000100000,
        PH_SENS    = 9'b001000000,
        PH_LED_CNT = 9'b010000000,
        PH_LED_VAL = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [2:0] frame_kind;
        logic [7:0] value_a;
        logic [7:0] value_b;
        logic [7:0] led_index;
        logic       last_of_frame;
        logic [7:0] discarded;
    } result_t;

endpackage

// ===== design/reply_frame_parser.sv =====
// ----------------------------------------------------------------------------
// reply_frame_parser
// Byte-serial parser for device reply frames, one result per completed item.
// ----------------------------------------------------------------------------
// Input channel s_*: one received byte per transfer (s_rx_byte).
// Result channel m_*: frame kind, two values, LED index, last mark and the
// count of bytes dropped while hunting for the 'O','K' sync pair.
// Bytes that complete no result (sync, function codes of multi-byte frames,
// counts, first curtain byte) are absorbed without an output transfer.
// A result is registered on m_*, or parked in the skid entry while the
// receiver stalls. Throughput: one byte per cycle while s_ready is high;
// the frame state machine decides each byte in the cycle it is taken.
// The result register is backed by a one-entry skid stage: while the
// receiver stalls, bytes that form no result are still taken and one more
// result parks in the skid entry; s_ready then drops until the skid entry
// moves out.
// Reset (aresetn low, synchronous): hunt for the first sync byte, drop
// count zero, both result stages empty.
// ----------------------------------------------------------------------------
module reply_frame_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_frame_kind,
    output logic [7:0] m_value_a,
    output logic [7:0] m_value_b,
    output logic [7:0] m_led_index,
    output logic       m_last_of_frame,
    output logic [7:0] m_discarded
);

    logic             accept;
    logic             res_valid;
    rfp_pkg::result_t res;
    rfp_pkg::result_t out_data;

    assign accept = s_valid && s_ready;

    rfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    rfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .ready     (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_frame_kind    = out_data.frame_kind;
    assign m_value_a       = out_data.value_a;
    assign m_value_b       = out_data.value_b;
    assign m_led_index     = out_data.led_index;
    assign m_last_of_frame = out_data.last_of_frame;
    assign m_discarded     = out_data.discarded;

endmodule

// ===== design/rfp_parser.sv =====
// ----------------------------------------------------------------------------
// rfp_parser
// Frame state machine: takes one byte per transfer and forms at most one
// result in the same cycle.
// ----------------------------------------------------------------------------
`include "reply_frame_parser_assert.svh"

module rfp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output rfp_pkg::result_t  res
);

    rfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] led_position_reg, led_position_next;
    logic [7:0] held_payload_reg, held_payload_next;
    logic [7:0] drop_count_reg, drop_count_next;
    logic [1:0] drop_inc;
    logic [8:0] drop_sum;
    logic       emit;

    always_comb begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        led_position_next = led_position_reg;
        held_payload_next = held_payload_reg;
        drop_inc          = 2'd0;
        emit              = 1'b0;
        res               = '0;
        res.discarded     = drop_count_reg;

        unique case (phase_reg)
            rfp_pkg::PH_HUNT_K: begin
                if (rx_byte == rfp_pkg::SYNC_SECOND) begin
                    phase_next = rfp_pkg::PH_FUNC;
                end else if (rx_byte == rfp_pkg::SYNC_FIRST) begin
                    // earlier sync byte is dropped, this one may start the pair
                    drop_inc = 2'd1;
                end else begin
                    drop_inc   = 2'd2;
                    phase_next = rfp_pkg::PH_HUNT_O;
                end
            end
            rfp_pkg::PH_FUNC: begin
                unique case (rx_byte)
                    rfp_pkg::FN_ACK: begin
                        emit              = 1'b1;
                        res.frame_kind    = rfp_pkg::KIND_ACK;
                        res.last_of_frame = 1'b1;
                    end
                    rfp_pkg::FN_CURTAIN: phase_next = rfp_pkg::PH_CUR_POS;
                    rfp_pkg::FN_INIT:    phase_next = rfp_pkg::PH_INIT;
                    rfp_pkg::FN_SENSORS: phase_next = rfp_pkg::PH_SENS;
                    rfp_pkg::FN_LEDS:    phase_next = rfp_pkg::PH_LED_CNT;
                    default: begin
                        emit              = 1'b1;
                        res.frame_kind    = rfp_pkg::KIND_UNKNOWN;
                        res.value_a       = rx_byte;
                        res.last_of_frame = 1'b1;
                    end
                endcase
            end
            rfp_pkg::PH_CUR_POS: begin
                held_payload_next = rx_byte;
                phase_next        = rfp_pkg::PH_CUR_MAX;
            end
            rfp_pkg::PH_CUR_MAX: begin
                emit              = 1'b1;
                res.frame_kind    = rfp_pkg::KIND_CURTAIN;
                res.value_a       = held_payload_reg;
                res.value_b       = rx_byte;
                res.last_of_frame = 1'b1;
            end
            rfp_pkg::PH_INIT: begin
                emit              = 1'b1;
                res.frame_kind    = rfp_pkg::KIND_INIT;
                res.value_a       = rx_byte;
                res.last_of_frame = 1'b1;
            end
            rfp_pkg::PH_SENS: begin
                emit              = 1'b1;
                res.frame_kind    = rfp_pkg::KIND_SENSORS;
                res.value_a       = rx_byte;
                res.last_of_frame = 1'b1;
            end
            rfp_pkg::PH_LED_CNT: begin
                remaining_next    = rx_byte;
                led_position_next = 8'd0;
                if (rx_byte == 8'd0) begin
                    emit              = 1'b1;
                    res.frame_kind    = rfp_pkg::KIND_LED_EMPTY;
                    res.last_of_frame = 1'b1;
                end else begin
                    phase_next = rfp_pkg::PH_LED_VAL;
                end
            end
            rfp_pkg::PH_LED_VAL: begin
                emit              = 1'b1;
                res.frame_kind    = rfp_pkg::KIND_LED;
                res.value_a       = rx_byte;
                res.led_index     = led_position_reg;
                res.last_of_frame = (remaining_reg <= 8'd1);
                led_position_next = led_position_reg + 8'd1;
                remaining_next    = (remaining_reg == 8'd0) ? 8'd0 : remaining_reg - 8'd1;
            end
            default: begin
                // hunting for the first sync byte
                if (rx_byte == rfp_pkg::SYNC_FIRST) begin
                    phase_next = rfp_pkg::PH_HUNT_K;
                end else begin
                    phase_next = rfp_pkg::PH_HUNT_O;
                    drop_inc   = 2'd1;
                end
            end
        endcase

        drop_sum        = {1'b0, drop_count_reg} + {7'd0, drop_inc};
        drop_count_next = drop_sum[8] ? 8'hFF : drop_sum[7:0];

        // frame done: clear the drop counter and resume hunting
        if (emit && res.last_of_frame) begin
            drop_count_next = 8'd0;
            phase_next      = rfp_pkg::PH_HUNT_O;
        end
    end

    assign res_valid = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= rfp_pkg::PH_HUNT_O;
            remaining_reg    <= 8'd0;
            led_position_reg <= 8'd0;
            held_payload_reg <= 8'd0;
            drop_count_reg   <= 8'd0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            led_position_reg <= led_position_next;
            held_payload_reg <= held_payload_next;
            drop_count_reg   <= drop_count_next;
        end
    end

    `RFP_ASSERT_NXT(a_drop_clear, aclk, aresetn, res_valid && res.last_of_frame, drop_count_reg == 8'd0)
    `RFP_ASSERT_NXT(a_led_advance, aclk, aresetn, accept && phase_reg == rfp_pkg::PH_LED_VAL && remaining_reg > 8'd1, led_position_reg == $past(led_position_reg) + 8'd1 && phase_reg == rfp_pkg::PH_LED_VAL)
    `RFP_ASSERT_NXT(a_sync_pair, aclk, aresetn, accept && phase_reg == rfp_pkg::PH_HUNT_K && rx_byte == rfp_pkg::SYNC_SECOND, phase_reg == rfp_pkg::PH_FUNC)

endmodule

// ===== design/rfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// rfp_out_reg
// Result register with a one-entry skid stage, so the parser keeps taking
// bytes while a result waits for the receiver.
// ----------------------------------------------------------------------------
`include "reply_frame_parser_assert.svh"

module rfp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rfp_pkg::result_t  push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rfp_pkg::result_t  out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    rfp_pkg::result_t out_data_reg, out_data_next;
    rfp_pkg::result_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                // drain the skid entry first
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            // hold the waiting result, park the new one
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `RFP_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `RFP_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !skid_valid_reg)
    `RFP_ASSERT_NXT(a_park, aclk, aresetn, push && out_valid_reg && !out_ready, skid_valid_reg && skid_data_reg == $past(push_data))

endmodule

// ===== dv/tb_reply_frame_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reply_frame_parser
// Self-checking bench for the reply frame parser. A queue of received bytes
// (directed frames, then random frames, sync loss and noise) feeds a
// valid/ready driver. Each accepted byte runs through a local frame parser
// that builds the expected results, and a monitor checks every result
// transfer against them while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_reply_frame_parser;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_frame_kind;
    logic [7:0] m_value_a;
    logic [7:0] m_value_b;
    logic [7:0] m_led_index;
    logic       m_last_of_frame;
    logic [7:0] m_discarded;

    reply_frame_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_kind    (m_frame_kind),
        .m_value_a       (m_value_a),
        .m_value_b       (m_value_b),
        .m_led_index     (m_led_index),
        .m_last_of_frame (m_last_of_frame),
        .m_discarded     (m_discarded)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [7:0]       rx_bytes[$];
    rfp_pkg::result_t pending_replies[$];
    int               errors = 0;
    int               results_checked = 0;
    int               bytes_accepted = 0;
    int               hold_left = 0;
    logic             hold_done = 1'b0;

    // local copy of the frame parser state
    rfp_pkg::phase_t ph = rfp_pkg::PH_HUNT_O;
    logic [7:0]      leds_left = 8'd0;
    logic [7:0]      led_pos = 8'd0;
    logic [7:0]      cur_pos = 8'd0;
    logic [7:0]      drops = 8'd0;

    task automatic add_drop(input int n);
        int c;
        c = drops + n;
        drops = (c > 255) ? 8'd255 : 8'(c);
    endtask

    task automatic push_reply(input logic [2:0] kind, input logic [7:0] a,
                              input logic [7:0] bv, input logic [7:0] idx,
                              input logic last);
        rfp_pkg::result_t r;
        r.frame_kind    = kind;
        r.value_a       = a;
        r.value_b       = bv;
        r.led_index     = idx;
        r.last_of_frame = last;
        r.discarded     = drops;
        pending_replies.push_back(r);
        if (last) begin
            drops = 8'd0;
            ph    = rfp_pkg::PH_HUNT_O;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] idx;
        logic       last;
        case (ph)
            rfp_pkg::PH_HUNT_K: begin
                if (b == rfp_pkg::SYNC_SECOND) begin
                    ph = rfp_pkg::PH_FUNC;
                end else if (b == rfp_pkg::SYNC_FIRST) begin
                    add_drop(1);
                end else begin
                    add_drop(2);
                    ph = rfp_pkg::PH_HUNT_O;
                end
            end
            rfp_pkg::PH_FUNC: begin
                case (b)
                    rfp_pkg::FN_ACK:
                        push_reply(rfp_pkg::KIND_ACK, 8'd0, 8'd0, 8'd0, 1'b1);
                    rfp_pkg::FN_CURTAIN: ph = rfp_pkg::PH_CUR_POS;
                    rfp_pkg::FN_INIT:    ph = rfp_pkg::PH_INIT;
                    rfp_pkg::FN_SENSORS: ph = rfp_pkg::PH_SENS;
                    rfp_pkg::FN_LEDS:    ph = rfp_pkg::PH_LED_CNT;
                    default:
                        push_reply(rfp_pkg::KIND_UNKNOWN, b, 8'd0, 8'd0, 1'b1);
                endcase
            end
            rfp_pkg::PH_CUR_POS: begin
                cur_pos = b;
                ph      = rfp_pkg::PH_CUR_MAX;
            end
            rfp_pkg::PH_CUR_MAX:
                push_reply(rfp_pkg::KIND_CURTAIN, cur_pos, b, 8'd0, 1'b1);
            rfp_pkg::PH_INIT:
                push_reply(rfp_pkg::KIND_INIT, b, 8'd0, 8'd0, 1'b1);
            rfp_pkg::PH_SENS:
                push_reply(rfp_pkg::KIND_SENSORS, b, 8'd0, 8'd0, 1'b1);
            rfp_pkg::PH_LED_CNT: begin
                leds_left = b;
                led_pos   = 8'd0;
                if (b == 8'd0) begin
                    push_reply(rfp_pkg::KIND_LED_EMPTY, 8'd0, 8'd0, 8'd0, 1'b1);
                end else begin
                    ph = rfp_pkg::PH_LED_VAL;
                end
            end
            rfp_pkg::PH_LED_VAL: begin
                idx  = led_pos;
                last = (leds_left <= 8'd1);
                led_pos = led_pos + 8'd1;
                if (leds_left != 8'd0) leds_left = leds_left - 8'd1;
                push_reply(rfp_pkg::KIND_LED, b, 8'd0, idx, last);
            end
            default: begin
                // hunting for the first sync byte
                if (b == rfp_pkg::SYNC_FIRST) begin
                    ph = rfp_pkg::PH_HUNT_K;
                end else begin
                    ph = rfp_pkg::PH_HUNT_O;
                    add_drop(1);
                end
            end
        endcase
    endtask

    function automatic logic calm_window();
        return (bytes_accepted >= 100) && (bytes_accepted < 260);
    endfunction

    // driver: predict on each transfer, then offer the next byte or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_rx_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (rx_bytes.size() != 0 &&
                    (calm_window() || $urandom_range(0, 99) >= 34)) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, while the sender keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_accepted >= 300) begin
            hold_left <= 120;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        rfp_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                             $time, m_frame_kind, m_value_a);
                    errors++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("frame_kind", {5'd0, want.frame_kind},
                                {5'd0, m_frame_kind});
                    check_field("value_a", want.value_a, m_value_a);
                    check_field("value_b", want.value_b, m_value_b);
                    check_field("led_index", want.led_index, m_led_index);
                    check_field("last_of_frame", {7'd0, want.last_of_frame},
                                {7'd0, m_last_of_frame});
                    check_field("discarded", want.discarded, m_discarded);
                    results_checked++;
                end
            end
            m_ready <= (hold_left == 0) && (calm_window() || $urandom_range(0, 99) >= 34);
        end
    end

    task automatic put(input logic [7:0] b);
        rx_bytes.push_back(b);
    endtask

    task automatic put_sync();
        put(rfp_pkg::SYNC_FIRST);
        put(rfp_pkg::SYNC_SECOND);
    endtask

    task automatic gen_frame(input int led_max);
        int         n;
        logic [7:0] fn;
        put_sync();
        case ($urandom_range(0, 5))
            0: put(rfp_pkg::FN_ACK);
            1: begin
                put(rfp_pkg::FN_CURTAIN);
                put(8'($urandom_range(0, 255)));
                put(8'($urandom_range(0, 255)));
            end
            2: begin
                put(rfp_pkg::FN_INIT);
                put(8'($urandom_range(0, 255)));
            end
            3: begin
                put(rfp_pkg::FN_SENSORS);
                put(8'($urandom_range(0, 255)));
            end
            4: begin
                n = $urandom_range(0, led_max);
                put(rfp_pkg::FN_LEDS);
                put(8'(n));
                repeat (n) put(8'($urandom_range(0, 255)));
            end
            default: begin
                do fn = 8'($urandom_range(0, 255));
                while (fn == rfp_pkg::FN_ACK || fn == rfp_pkg::FN_CURTAIN ||
                       fn == rfp_pkg::FN_INIT || fn == rfp_pkg::FN_SENSORS ||
                       fn == rfp_pkg::FN_LEDS);
                put(fn);
            end
        endcase
    endtask

    initial begin : stimulus
        int         iter;
        logic [7:0] junk;

        iter = 0;

        // clean ack, then curtain after junk and a repeated first sync byte
        put_sync(); put(rfp_pkg::FN_ACK);
        put(8'h00); put(8'hFF); put(rfp_pkg::SYNC_FIRST); put_sync();
        put(rfp_pkg::FN_CURTAIN); put(8'h00); put(8'hFF);
        // first sync byte not followed by the second
        put(rfp_pkg::SYNC_FIRST); put(8'h55); put_sync(); put(rfp_pkg::FN_INIT); put(8'hFF);
        put_sync(); put(rfp_pkg::FN_SENSORS); put(8'hA5);
        // empty LED frame, then LED values that look like sync
        put_sync(); put(rfp_pkg::FN_LEDS); put(8'h00);
        put_sync(); put(rfp_pkg::FN_LEDS); put(8'h02);
        put(rfp_pkg::SYNC_FIRST); put(rfp_pkg::SYNC_SECOND);
        put_sync(); put(8'h00);
        put_sync(); put(8'hFF);

        while (rx_bytes.size() < 560) begin
            iter++;
            if (iter == 2) begin
                // longest LED frame: indexes up to 254
                put_sync(); put(rfp_pkg::FN_LEDS); put(8'hFF);
                repeat (255) put(8'($urandom_range(0, 255)));
            end
            if (iter == 3) begin
                // enough junk to saturate the drop count
                repeat (258) begin
                    junk = 8'($urandom_range(0, 255));
                    put((junk == rfp_pkg::SYNC_FIRST) ? 8'h00 : junk);
                end
                gen_frame(4);
            end
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
                end
                gen_frame(6);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        put(rfp_pkg::SYNC_FIRST);
                        junk = 8'($urandom_range(0, 255));
                        put((junk == rfp_pkg::SYNC_SECOND) ? 8'h4A : junk);
                    end
                    1: begin
                        put(rfp_pkg::SYNC_FIRST);
                        put(rfp_pkg::SYNC_FIRST);
                    end
                    default: repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
                endcase
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (rx_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes and checked %0d results: all frame kinds, sync loss,",
                 bytes_accepted, results_checked);
        $display("drop saturation and a full LED frame, under random and long stalls.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rfp_pkg.sv
design/rfp_parser.sv
design/rfp_out_reg.sv
design/reply_frame_parser.sv
dv/tb_reply_frame_parser.sv
